[hw/rtl/argb_gray_nearest_downscale_assert.svh]
// ----------------------------------------------------------------------------
// argb_gray_nearest_downscale assertion macros
// shared property forms for the downscaler checkers
// ----------------------------------------------------------------------------
`ifndef ARGB_GRAY_NEAREST_DOWNSCALE_ASSERT_SVH
`define ARGB_GRAY_NEAREST_DOWNSCALE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define AGND_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define AGND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/agnd_pkg.sv]
// ----------------------------------------------------------------------------
// agnd_pkg
// shared constants, types and helpers of the argb to gray downscaler
// ----------------------------------------------------------------------------
package agnd_pkg;

    localparam int MAX_DIMENSION = 1024;

    // register and field widths fixed by the interface
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 32;
    localparam int GRAY_W    = 8;

    // widths that follow from the largest frame size
    localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
    localparam int SRC_W  = $clog2(MAX_DIMENSION);
    localparam int ACC_W  = $clog2(MAX_DIMENSION * MAX_DIMENSION + MAX_DIMENSION + 1);
    localparam int WIDE_W = (CFG_W > DIM_W) ? CFG_W : DIM_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT   = 2'd3;

    localparam logic [CFG_W-1:0] RST_SOURCE_WIDTH  = 11'd480;
    localparam logic [CFG_W-1:0] RST_SOURCE_HEIGHT = 11'd272;
    localparam logic [CFG_W-1:0] RST_DEST_WIDTH    = 11'd65;
    localparam logic [CFG_W-1:0] RST_DEST_HEIGHT   = 11'd65;

    // luma weights, sum to 256
    localparam logic [7:0] LUMA_R = 8'd54;
    localparam logic [7:0] LUMA_G = 8'd184;
    localparam logic [7:0] LUMA_B = 8'd18;

    typedef struct packed {
        logic [DIM_W-1:0] sw;
        logic [DIM_W-1:0] sh;
        logic [DIM_W-1:0] dw;
        logic [DIM_W-1:0] dh;
    } dims_t;

    typedef struct packed {
        logic hit;
        logic row_end;
        logic frame_end;
    } pick_t;

    // saturate into 1..hi
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (WIDE_W'(v) > WIDE_W'(hi))
            r = hi;
        else
            r = DIM_W'(v);
        return r;
    endfunction

    function automatic logic [GRAY_W-1:0] luma8(input logic [PIX_W-1:0] px);
        logic [15:0] sum;
        sum = 16'(LUMA_R) * 16'(px[23:16]) + 16'(LUMA_G) * 16'(px[15:8])
              + 16'(LUMA_B) * 16'(px[7:0]);
        return sum[15:8];
    endfunction

endpackage

[hw/rtl/agnd_ifs.sv]
// ----------------------------------------------------------------------------
// agnd channel interfaces
// pixel input, gray output and register write channels
// ----------------------------------------------------------------------------
interface agnd_pixel_if;
    logic        valid;
    logic        ready;
    logic [31:0] argb_pixel;
    logic        frame_start;

    modport source (output valid, argb_pixel, frame_start, input ready);
    modport sink   (input valid, argb_pixel, frame_start, output ready);
endinterface

interface agnd_gray_if;
    logic       valid;
    logic       ready;
    logic [7:0] gray_level;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, gray_level, row_end, frame_end, input ready);
    modport sink   (input valid, gray_level, row_end, frame_end, output ready);
endinterface

interface agnd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/agnd_cfg.sv]
// ----------------------------------------------------------------------------
// agnd_cfg
// size registers and their clamped working values
// ----------------------------------------------------------------------------
module agnd_cfg
    import agnd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    agnd_cfg_if.sink    cfg,
    output dims_t       dims
);

    logic [CFG_W-1:0] source_width_reg;
    logic [CFG_W-1:0] source_height_reg;
    logic [CFG_W-1:0] dest_width_reg;
    logic [CFG_W-1:0] dest_height_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= RST_SOURCE_WIDTH;
            source_height_reg <= RST_SOURCE_HEIGHT;
            dest_width_reg    <= RST_DEST_WIDTH;
            dest_height_reg   <= RST_DEST_HEIGHT;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SOURCE_WIDTH:  source_width_reg  <= cfg.data;
                REG_SOURCE_HEIGHT: source_height_reg <= cfg.data;
                REG_DEST_WIDTH:    dest_width_reg    <= cfg.data;
                REG_DEST_HEIGHT:   dest_height_reg   <= cfg.data;
            endcase
        end
    end

    // destination never larger than source
    always_comb
    begin
        dims.sw = clamp_dim(source_width_reg, DIM_W'(MAX_DIMENSION));
        dims.sh = clamp_dim(source_height_reg, DIM_W'(MAX_DIMENSION));
        dims.dw = clamp_dim(dest_width_reg, dims.sw);
        dims.dh = clamp_dim(dest_height_reg, dims.sh);
    end

endmodule

[hw/rtl/agnd_pick.sv]
// ----------------------------------------------------------------------------
// agnd_pick
// raster position counters and accumulators that pick the nearest pixels
// ----------------------------------------------------------------------------
module agnd_pick
    import agnd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  logic  frame_start,
    input  dims_t dims,
    output pick_t pick
);

    logic [SRC_W-1:0] src_column_reg, src_column_next;
    logic [SRC_W-1:0] src_row_reg, src_row_next;
    logic [DIM_W-1:0] dst_column_reg, dst_column_next;
    logic [DIM_W-1:0] dst_row_reg, dst_row_next;
    logic [ACC_W-1:0] col_target_acc_reg, col_target_acc_next;
    logic [ACC_W-1:0] col_source_acc_reg, col_source_acc_next;
    logic [ACC_W-1:0] row_target_acc_reg, row_target_acc_next;
    logic [ACC_W-1:0] row_source_acc_reg, row_source_acc_next;

    // state as seen by this pixel, cleared by a frame start
    logic [SRC_W-1:0] src_col_e, src_row_e;
    logic [DIM_W-1:0] dst_col_e, dst_row_e;
    logic [ACC_W-1:0] ct_e, cs_e, rt_e, rs_e;
    logic             col_hit, row_hit;

    always_comb
    begin
        src_col_e = frame_start ? '0 : src_column_reg;
        src_row_e = frame_start ? '0 : src_row_reg;
        dst_col_e = frame_start ? '0 : dst_column_reg;
        dst_row_e = frame_start ? '0 : dst_row_reg;
        ct_e      = frame_start ? '0 : col_target_acc_reg;
        cs_e      = frame_start ? '0 : col_source_acc_reg;
        rt_e      = frame_start ? '0 : row_target_acc_reg;
        rs_e      = frame_start ? '0 : row_source_acc_reg;

        col_hit = (dst_col_e < dims.dw)
                  && ({1'b0, ct_e} < ({1'b0, cs_e} + (ACC_W + 1)'(dims.dw)));
        row_hit = (dst_row_e < dims.dh)
                  && ({1'b0, rt_e} < ({1'b0, rs_e} + (ACC_W + 1)'(dims.dh)));

        pick.hit       = col_hit && row_hit;
        pick.row_end   = (dst_col_e == dims.dw - DIM_W'(1));
        pick.frame_end = pick.row_end && (dst_row_e == dims.dh - DIM_W'(1));

        dst_column_next     = col_hit ? dst_col_e + DIM_W'(1) : dst_col_e;
        col_target_acc_next = col_hit ? ct_e + ACC_W'(dims.sw) : ct_e;
        col_source_acc_next = cs_e + ACC_W'(dims.dw);
        src_column_next     = src_col_e + SRC_W'(1);
        src_row_next        = src_row_e;
        dst_row_next        = dst_row_e;
        row_target_acc_next = rt_e;
        row_source_acc_next = rs_e;

        // last pixel of a source row
        if (DIM_W'(src_col_e) >= dims.sw - DIM_W'(1))
        begin
            src_column_next     = '0;
            dst_column_next     = '0;
            col_target_acc_next = '0;
            col_source_acc_next = '0;
            if (row_hit)
            begin
                dst_row_next        = dst_row_e + DIM_W'(1);
                row_target_acc_next = rt_e + ACC_W'(dims.sh);
            end
            row_source_acc_next = rs_e + ACC_W'(dims.dh);
            if (DIM_W'(src_row_e) >= dims.sh - DIM_W'(1))
            begin
                src_row_next        = '0;
                dst_row_next        = '0;
                row_target_acc_next = '0;
                row_source_acc_next = '0;
            end
            else
            begin
                src_row_next = src_row_e + SRC_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_column_reg     <= '0;
            src_row_reg        <= '0;
            dst_column_reg     <= '0;
            dst_row_reg        <= '0;
            col_target_acc_reg <= '0;
            col_source_acc_reg <= '0;
            row_target_acc_reg <= '0;
            row_source_acc_reg <= '0;
        end
        else if (step)
        begin
            src_column_reg     <= src_column_next;
            src_row_reg        <= src_row_next;
            dst_column_reg     <= dst_column_next;
            dst_row_reg        <= dst_row_next;
            col_target_acc_reg <= col_target_acc_next;
            col_source_acc_reg <= col_source_acc_next;
            row_target_acc_reg <= row_target_acc_next;
            row_source_acc_reg <= row_source_acc_next;
        end
    end

endmodule

[hw/rtl/agnd_out_stage.sv]
// ----------------------------------------------------------------------------
// agnd_out_stage
// luma weighting and the result register toward the gray channel
// ----------------------------------------------------------------------------
module agnd_out_stage
    import agnd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [PIX_W-1:0] pixel,
    input  pick_t            pick,
    output logic             free,
    agnd_gray_if.source      grays
);

    logic              valid_reg;
    logic [GRAY_W-1:0] gray_reg;
    logic              row_end_reg;
    logic              frame_end_reg;

    assign free = !valid_reg || grays.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (grays.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            gray_reg      <= luma8(pixel);
            row_end_reg   <= pick.row_end;
            frame_end_reg <= pick.frame_end;
        end
    end

    assign grays.valid      = valid_reg;
    assign grays.gray_level = gray_reg;
    assign grays.row_end    = row_end_reg;
    assign grays.frame_end  = frame_end_reg;

endmodule

[hw/rtl/argb_gray_nearest_downscale.sv]
// ----------------------------------------------------------------------------
// argb_gray_nearest_downscale
// nearest-neighbor downscaler from an argb raster stream to 8-bit gray
// ----------------------------------------------------------------------------
//  channel  dir  payload                          request moves
//  pixels   in   argb_pixel, frame_start          one source pixel
//  grays    out  gray_level, row_end, frame_end   one picked gray pixel
//  cfg      in   index, data                      one size register write
//
//  one pixel per clock sustained while grays is not stalled; a picked pixel
//  reaches grays through the input register and then the result register
//  reset clears position state and loads the default sizes
//  a stalled grays channel holds one result and one pixel in flight, then
//  pixels.ready drops; pixels that are not picked leave no result
//  cfg is always ready; registers take effect on the next pixel
// ----------------------------------------------------------------------------
module argb_gray_nearest_downscale
    import agnd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    agnd_pixel_if.sink  pixels,
    agnd_gray_if.source grays,
    agnd_cfg_if.sink    cfg
);

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic             s1_start_reg;
    logic             out_free;
    logic             advance;
    dims_t            dims;
    pick_t            pick;

    assign advance      = s1_valid_reg && out_free;
    assign pixels.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pixels.ready)
            s1_valid_reg <= pixels.valid;
    end

    always_ff @(posedge clk)
    begin
        if (pixels.ready && pixels.valid)
        begin
            s1_pixel_reg <= pixels.argb_pixel;
            s1_start_reg <= pixels.frame_start;
        end
    end

    agnd_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .dims  (dims)
    );

    agnd_pick u_pick (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .frame_start (s1_start_reg),
        .dims        (dims),
        .pick        (pick)
    );

    agnd_out_stage u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance && pick.hit),
        .pixel (s1_pixel_reg),
        .pick  (pick),
        .free  (out_free),
        .grays (grays)
    );

endmodule

[hw/rtl/agnd_checker.sv]
// ----------------------------------------------------------------------------
// agnd_checker
// port-level checks on the downscaler, bound to the top level
// ----------------------------------------------------------------------------
`include "argb_gray_nearest_downscale_assert.svh"

module agnd_checker
    import agnd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [GRAY_W-1:0] out_gray,
    input logic              out_row_end,
    input logic              out_frame_end
);

    `AGND_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_gray) && $stable(out_row_end) && $stable(out_frame_end), "stalled result changed")

    `AGND_ASSERT_IMPL(a_frame_row_end, clk, rst_n, out_valid && out_frame_end, out_row_end, "frame end without row end")

    // a new result needs a request accepted earlier
    `AGND_ASSERT_IMPL(a_out_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without request")

    // input only backs up behind a stalled result
    `AGND_ASSERT_IMPL(a_backpressure, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled while output free")

endmodule

bind argb_gray_nearest_downscale agnd_checker u_agnd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pixels.valid),
    .in_ready      (pixels.ready),
    .out_valid     (grays.valid),
    .out_ready     (grays.ready),
    .out_gray      (grays.gray_level),
    .out_row_end   (grays.row_end),
    .out_frame_end (grays.frame_end)
);
